// ----- hdl/grc_pkg.sv -----
`timescale 1ns / 1ps

package grc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int HALF      = ONE / 2;
	localparam int MAP_DIM   = 64;
	localparam int TILE_W    = $clog2(MAP_DIM);
	localparam int ADDR_W    = 2 * TILE_W;
	localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;
	localparam int CLR_W     = ADDR_W + 1;

	localparam int POS_W  = 22;
	localparam int DIR_W  = 18;
	localparam int MAG_W  = 18;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int LEN_W  = SQ_W / 2;
	localparam int NUM_W  = LEN_W + FRAC_BITS;
	localparam int DIST_W = 36;
	localparam int ACC_W  = DIST_W + MAG_W;
	localparam int M_W    = ACC_W - FRAC_BITS;
	localparam int HIT_W  = 40;
	localparam int CX_W   = HIT_W - FRAC_BITS;
	localparam int OUT_W  = 25;
	localparam int T_W    = 10;
	localparam int EPS_W  = 8;
	localparam int CNT_W  = 8;
	localparam int RD_W   = 3;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic signed [HIT_W-1:0] OUT_HI = HIT_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [HIT_W-1:0] OUT_LO = -HIT_W'(1 << (OUT_W - 1));

	localparam logic [EPS_W-1:0] EPS_RESET  = 8'd1;
	localparam logic [CNT_W-1:0] STEP_RESET = 8'd100;

	// register indexes on the configuration port
	localparam logic REG_EPS  = 1'b0;
	localparam logic REG_STEP = 1'b1;

	// input item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_CAST  = 1'b1;

	// tile read slots: four corner neighbours, then the entered tile
	localparam logic [RD_W-1:0] RD_C00  = 3'd0;
	localparam logic [RD_W-1:0] RD_C10  = 3'd1;
	localparam logic [RD_W-1:0] RD_C01  = 3'd2;
	localparam logic [RD_W-1:0] RD_C11  = 3'd3;
	localparam logic [RD_W-1:0] RD_TILE = 3'd4;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_SQRT,
		S_DIVX,
		S_DIVY,
		S_INITX,
		S_INITY,
		S_STEP,
		S_MULX,
		S_MULY,
		S_HIT,
		S_RDA,
		S_RDW,
		S_ADV,
		S_FINX,
		S_FINY,
		S_EMIT
	} state_t;

	function automatic logic on_grid(input logic [FRAC_BITS-1:0] f,
			input logic [EPS_W-1:0] eps);
		logic [FRAC_BITS:0] fe;
		logic [FRAC_BITS:0] ee;
		fe = (FRAC_BITS + 1)'(f);
		ee = (FRAC_BITS + 1)'(eps);
		return (fe < ee) || (((FRAC_BITS + 1)'(ONE) - fe) < ee);
	endfunction

	function automatic logic [OUT_W-1:0] sat_out(input logic signed [HIT_W-1:0] v);
		logic signed [HIT_W-1:0] c;
		c = v;
		if (v > OUT_HI) c = OUT_HI;
		if (v < OUT_LO) c = OUT_LO;
		return c[OUT_W-1:0];
	endfunction

endpackage

// ----- hdl/grc_map.sv -----
`timescale 1ns / 1ps

module grc_map import grc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic              wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic              rdata,
	output logic              ready
);

	logic             mem_q [0:MAP_DEPTH-1];
	logic [CLR_W-1:0] clr_q;
	logic             rdata_q;

	assign ready = clr_q[CLR_W-1];
	assign rdata = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[CLR_W-1]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// sweep zeros through the map after reset, then take tile writes
	always_ff @(posedge clk) begin
		if (!clr_q[CLR_W-1]) begin
			mem_q[clr_q[ADDR_W-1:0]] <= 1'b0;
		end else if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// ----- hdl/grc_div.sv -----
`timescale 1ns / 1ps

module grc_div import grc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [MAG_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int DC_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [DC_W-1:0]  cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [MAG_W-1:0] den_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DC_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit a cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? MAG_W'(trial - {1'b0, den_q}) : trial[MAG_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

endmodule

// ----- hdl/grid_ray_caster_core.sv -----
`timescale 1ns / 1ps

// Channel  Handshake                 Payload
// in       in_valid / in_ready       kind, tile_x, tile_y, tile_wall, pos_x, pos_y, dir_x, dir_y
// out      out_valid / out_ready     hit_x, hit_y, corner_hit, found
// cfg      psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// A tile write goes straight into the map. A cast first runs its setup (squares,
// an 18-step square root, two 34-step divisions on the shared divider), then
// steps across grid crossings, each paced by four passes through the shared
// 18x18 multiplier and one to five map reads on the single read port.
// After reset a clearing pass over all 4096 map entries holds in_ready low.
// A finished result waits in the output register; the next cast stalls only
// at its end while the previous result is still untaken.

module grid_ray_caster_core import grc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    kind,
	input  logic [TILE_W-1:0]       tile_x,
	input  logic [TILE_W-1:0]       tile_y,
	input  logic                    tile_wall,
	input  logic [POS_W-1:0]        pos_x,
	input  logic [POS_W-1:0]        pos_y,
	input  logic signed [DIR_W-1:0] dir_x,
	input  logic signed [DIR_W-1:0] dir_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] hit_x,
	output logic signed [OUT_W-1:0] hit_y,
	output logic                    corner_hit,
	output logic                    found
);

	state_t state_q, state_n;

	logic [EPS_W-1:0] eps_q;
	logic [CNT_W-1:0] step_lim_q;

	logic [POS_W-1:0]  px_q, py_q;
	logic              vx_neg_q, vy_neg_q, vx_pos_q, vy_pos_q;
	logic [MAG_W-1:0]  mag_x_q, mag_y_q;
	logic [SQ_W-1:0]   sq_q, root_q, bit_q;
	logic [DIST_W-1:0] ux_q, uy_q, dx_q, dy_q, dist_q;
	logic              take_x_q;
	logic signed [T_W-1:0] tx_q, ty_q;
	logic [ACC_W-1:0]  acc_q;
	logic [M_W-1:0]    mx_q, my_q;
	logic signed [HIT_W-1:0] hx_q, hy_q;
	logic signed [CX_W-1:0]  cx_q, cy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RD_W-1:0]   rd_idx_q;
	logic              oob_q;
	logic              ph_q;
	logic [OUT_W-1:0]  res_x_q, res_y_q;
	logic              res_corner_q, res_found_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_x_q, out_y_q;
	logic              out_corner_q, out_found_q;

	logic              map_ready, map_rdata, map_we;
	logic [ADDR_W-1:0] map_waddr, map_raddr;
	logic              div_start, div_done;
	logic [NUM_W-1:0]  div_quo;
	logic [MAG_W-1:0]  div_den;

	logic [MAG_W-1:0]  mul_a, mul_b;
	logic [SQ_W-1:0]   prod;
	logic [ACC_W-1:0]  mac_sum;
	logic [DIST_W-1:0] init_dist;
	logic [SQ_W-1:0]   sq_trial;
	logic              sq_ge;
	logic [FRAC_BITS:0] frac_x, frac_y;
	logic signed [HIT_W-1:0] hx_n, hy_n, hx_rnd, hy_rnd, fin_n;
	logic              corner_n;
	logic signed [CX_W-1:0] rd_x, rd_y;
	logic              rd_oob, wall;
	logic [DIST_W:0]   adv_sum;
	logic              cfg_wr, in_xfer, out_load;

	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_STEP) ? 32'(step_lim_q) : 32'(eps_q);
	assign in_xfer  = in_valid && in_ready;
	assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign map_we    = in_xfer && (kind == KIND_WRITE);
	assign map_waddr = {tile_y, tile_x};

	assign out_valid  = out_valid_q;
	assign hit_x      = out_x_q;
	assign hit_y      = out_y_q;
	assign corner_hit = out_corner_q;
	assign found      = out_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q      <= EPS_RESET;
			step_lim_q <= STEP_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_EPS:  eps_q      <= pwdata[EPS_W-1:0];
				REG_STEP: step_lim_q <= pwdata[CNT_W-1:0];
				default:  ;
			endcase
		end
	end

	grc_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (map_we),
		.waddr  (map_waddr),
		.wdata  (tile_wall),
		.raddr  (map_raddr),
		.rdata  (map_rdata),
		.ready  (map_ready)
	);

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({root_q[LEN_W-1:0], FRAC_BITS'(0)}),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// shared datapath terms
	assign prod     = SQ_W'(mul_a) * SQ_W'(mul_b);
	assign mac_sum  = ph_q ? acc_q + {prod, MAG_W'(0)} : ACC_W'(prod);
	assign init_dist = (|mac_sum[ACC_W-1:FRAC_BITS+DIST_W]) ? DIST_MAX
		: mac_sum[FRAC_BITS+DIST_W-1:FRAC_BITS];
	assign sq_trial = root_q + bit_q;
	assign sq_ge    = sq_q >= sq_trial;
	assign frac_x   = vx_neg_q ? (FRAC_BITS + 1)'(px_q[FRAC_BITS-1:0])
		: (FRAC_BITS + 1)'(ONE) - (FRAC_BITS + 1)'(px_q[FRAC_BITS-1:0]);
	assign frac_y   = vy_neg_q ? (FRAC_BITS + 1)'(py_q[FRAC_BITS-1:0])
		: (FRAC_BITS + 1)'(ONE) - (FRAC_BITS + 1)'(py_q[FRAC_BITS-1:0]);
	assign hx_n = vx_neg_q ? HIT_W'(px_q) - HIT_W'(mx_q) : HIT_W'(px_q) + HIT_W'(mx_q);
	assign hy_n = vy_neg_q ? HIT_W'(py_q) - HIT_W'(my_q) : HIT_W'(py_q) + HIT_W'(my_q);
	assign hx_rnd = hx_n + HIT_W'(HALF);
	assign hy_rnd = hy_n + HIT_W'(HALF);
	assign corner_n = on_grid(hx_n[FRAC_BITS-1:0], eps_q) && on_grid(hy_n[FRAC_BITS-1:0], eps_q)
		&& ((mx_q > M_W'(eps_q)) || (my_q > M_W'(eps_q)));
	assign fin_n = (state_q == S_FINX)
		? (vx_neg_q ? HIT_W'(px_q) - HIT_W'(prod) : HIT_W'(px_q) + HIT_W'(prod))
		: (vy_neg_q ? HIT_W'(py_q) - HIT_W'(prod) : HIT_W'(py_q) + HIT_W'(prod));
	assign adv_sum = take_x_q ? {1'b0, dx_q} + {1'b0, ux_q} : {1'b0, dy_q} + {1'b0, uy_q};
	assign rd_oob  = rd_x[CX_W-1] || rd_y[CX_W-1]
		|| (rd_x >= CX_W'(MAP_DIM)) || (rd_y >= CX_W'(MAP_DIM));
	assign wall    = oob_q || map_rdata;

	always_comb begin
		rd_x = cx_q;
		rd_y = cy_q;
		case (rd_idx_q)
			RD_C00: begin
				rd_x = cx_q;
				rd_y = cy_q;
			end
			RD_C10: begin
				rd_x = cx_q - 1'b1;
				rd_y = cy_q;
			end
			RD_C01: begin
				rd_x = cx_q;
				rd_y = cy_q - 1'b1;
			end
			RD_C11: begin
				rd_x = cx_q - 1'b1;
				rd_y = cy_q - 1'b1;
			end
			default: begin
				rd_x = CX_W'(tx_q);
				rd_y = CX_W'(ty_q);
			end
		endcase
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:  if (in_xfer && kind == KIND_CAST) state_n = S_SQX;
			S_SQX:   state_n = S_SQY;
			S_SQY:   state_n = S_SQRT;
			S_SQRT:  if (cnt_q == CNT_W'(LEN_W - 1)) state_n = S_DIVX;
			S_DIVX:  if ((!ph_q && mag_x_q == '0) || (ph_q && div_done)) state_n = S_DIVY;
			S_DIVY:  if ((!ph_q && mag_y_q == '0) || (ph_q && div_done)) state_n = S_INITX;
			S_INITX: if (ph_q) state_n = S_INITY;
			S_INITY: if (ph_q) state_n = S_STEP;
			S_STEP:  state_n = (cnt_q == step_lim_q) ? S_FINX : S_MULX;
			S_MULX:  if (ph_q) state_n = S_MULY;
			S_MULY:  if (ph_q) state_n = S_HIT;
			S_HIT:   state_n = S_RDA;
			S_RDA:   state_n = S_RDW;
			S_RDW: begin
				if (wall) state_n = S_EMIT;
				else if (rd_idx_q == RD_TILE) state_n = S_ADV;
				else state_n = S_RDA;
			end
			S_ADV:   state_n = S_STEP;
			S_FINX:  state_n = S_FINY;
			S_FINY:  state_n = S_EMIT;
			S_EMIT:  if (out_load) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_den   = mag_x_q;
		map_raddr = {rd_y[TILE_W-1:0], rd_x[TILE_W-1:0]};
		unique case (state_q)
			S_IDLE:  in_ready = map_ready;
			S_SQX: begin
				mul_a = mag_x_q;
				mul_b = mag_x_q;
			end
			S_SQY: begin
				mul_a = mag_y_q;
				mul_b = mag_y_q;
			end
			S_DIVX: div_start = !ph_q && mag_x_q != '0;
			S_DIVY: begin
				div_den   = mag_y_q;
				div_start = !ph_q && mag_y_q != '0;
			end
			S_INITX: begin
				mul_a = MAG_W'(frac_x);
				mul_b = ph_q ? ux_q[DIST_W-1:MAG_W] : ux_q[MAG_W-1:0];
			end
			S_INITY: begin
				mul_a = MAG_W'(frac_y);
				mul_b = ph_q ? uy_q[DIST_W-1:MAG_W] : uy_q[MAG_W-1:0];
			end
			S_MULX: begin
				mul_a = ph_q ? dist_q[DIST_W-1:MAG_W] : dist_q[MAG_W-1:0];
				mul_b = mag_x_q;
			end
			S_MULY: begin
				mul_a = ph_q ? dist_q[DIST_W-1:MAG_W] : dist_q[MAG_W-1:0];
				mul_b = mag_y_q;
			end
			S_FINX: begin
				mul_a = MAG_W'(step_lim_q);
				mul_b = mag_x_q;
			end
			S_FINY: begin
				mul_a = MAG_W'(step_lim_q);
				mul_b = mag_y_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_SQY:  cnt_q <= '0;
				S_SQRT: cnt_q <= (cnt_q == CNT_W'(LEN_W - 1)) ? '0 : cnt_q + 1'b1;
				S_ADV:  cnt_q <= cnt_q + 1'b1;
				default: ;
			endcase
			case (state_q)
				S_DIVX: begin
					if (!ph_q && mag_x_q != '0) ph_q <= 1'b1;
					else if (div_done) ph_q <= 1'b0;
				end
				S_DIVY: begin
					if (!ph_q && mag_y_q != '0) ph_q <= 1'b1;
					else if (div_done) ph_q <= 1'b0;
				end
				S_INITX, S_INITY, S_MULX, S_MULY: ph_q <= ~ph_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q     <= pos_x;
				py_q     <= pos_y;
				vx_neg_q <= dir_x[DIR_W-1];
				vy_neg_q <= dir_y[DIR_W-1];
				vx_pos_q <= !dir_x[DIR_W-1] && dir_x != '0;
				vy_pos_q <= !dir_y[DIR_W-1] && dir_y != '0;
				mag_x_q  <= dir_x[DIR_W-1] ? MAG_W'(-dir_x) : MAG_W'(dir_x);
				mag_y_q  <= dir_y[DIR_W-1] ? MAG_W'(-dir_y) : MAG_W'(dir_y);
				tx_q     <= T_W'(pos_x[POS_W-1:FRAC_BITS]);
				ty_q     <= T_W'(pos_y[POS_W-1:FRAC_BITS]);
			end
			S_SQX: sq_q <= prod;
			S_SQY: begin
				sq_q   <= sq_q + prod;
				root_q <= '0;
				bit_q  <= SQ_W'(1) << (SQ_W - 2);
			end
			S_SQRT: begin
				// one root bit a cycle
				if (sq_ge) begin
					sq_q   <= sq_q - sq_trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIVX: begin
				if (!ph_q && mag_x_q == '0) ux_q <= DIST_MAX;
				else if (ph_q && div_done) ux_q <= DIST_W'(div_quo);
			end
			S_DIVY: begin
				if (!ph_q && mag_y_q == '0) uy_q <= DIST_MAX;
				else if (ph_q && div_done) uy_q <= DIST_W'(div_quo);
			end
			S_INITX: begin
				acc_q <= mac_sum;
				if (ph_q) dx_q <= init_dist;
			end
			S_INITY: begin
				acc_q <= mac_sum;
				if (ph_q) dy_q <= init_dist;
			end
			S_STEP: begin
				// ties go to the x crossing
				take_x_q <= dx_q <= dy_q;
				dist_q   <= (dx_q <= dy_q) ? dx_q : dy_q;
				if (dx_q <= dy_q) tx_q <= vx_pos_q ? tx_q + 1'b1 : tx_q - 1'b1;
				else ty_q <= vy_pos_q ? ty_q + 1'b1 : ty_q - 1'b1;
			end
			S_MULX: begin
				acc_q <= mac_sum;
				if (ph_q) mx_q <= mac_sum[ACC_W-1:FRAC_BITS];
			end
			S_MULY: begin
				acc_q <= mac_sum;
				if (ph_q) my_q <= mac_sum[ACC_W-1:FRAC_BITS];
			end
			S_HIT: begin
				hx_q     <= hx_n;
				hy_q     <= hy_n;
				cx_q     <= hx_rnd[HIT_W-1:FRAC_BITS];
				cy_q     <= hy_rnd[HIT_W-1:FRAC_BITS];
				rd_idx_q <= corner_n ? RD_C00 : RD_TILE;
			end
			S_RDA: oob_q <= rd_oob;
			S_RDW: begin
				if (rd_idx_q == RD_TILE) begin
					res_x_q      <= sat_out(hx_q);
					res_y_q      <= sat_out(hy_q);
					res_corner_q <= 1'b0;
				end else begin
					res_x_q      <= sat_out({cx_q, FRAC_BITS'(0)});
					res_y_q      <= sat_out({cy_q, FRAC_BITS'(0)});
					res_corner_q <= 1'b1;
				end
				res_found_q <= 1'b1;
				// after the last corner neighbour, test the entered tile
				rd_idx_q <= (rd_idx_q == RD_C11) ? RD_TILE : rd_idx_q + 1'b1;
			end
			S_ADV: begin
				if (take_x_q) dx_q <= adv_sum[DIST_W] ? DIST_MAX : adv_sum[DIST_W-1:0];
				else dy_q <= adv_sum[DIST_W] ? DIST_MAX : adv_sum[DIST_W-1:0];
			end
			S_FINX: res_x_q <= sat_out(fin_n);
			S_FINY: begin
				res_y_q      <= sat_out(fin_n);
				res_corner_q <= 1'b0;
				res_found_q  <= 1'b0;
			end
			default: ;
		endcase
		if (out_load) begin
			out_x_q      <= res_x_q;
			out_y_q      <= res_y_q;
			out_corner_q <= res_corner_q;
			out_found_q  <= res_found_q;
		end
	end

	a_emit_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_EMIT))
		else $error("result raised outside the emit step");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP) |-> (cnt_q <= step_lim_q))
		else $error("crossing count ran past the step limit");

	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == KIND_WRITE) |=> (state_q == S_IDLE))
		else $error("tile write started a cast");

	a_corner_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && corner_hit |-> found)
		else $error("corner result without a wall hit");

endmodule
